FILE: design/smf_pkg.sv
// smf_pkg: shared types and codes of the sliding median filter
// holds the sample type, register indexes, the cell control group and the sequencer states
// no dependencies
package smf_pkg;

	localparam int unsigned SAMPLE_W   = 24;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 4;
	localparam int unsigned WSIZE_W    = 4;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 2'd1;

	localparam logic [WSIZE_W-1:0] WSIZE_RESET = 4'd5;

	// control shared by every cell of the row
	typedef struct packed {
		logic load;    // beat taken with the filter on: shift history, reload ring
		logic rotate;  // ranking step: compare and pass the ring value on
	} smf_cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RANK,
		ST_OUT
	} smf_state_t;

endpackage

FILE: design/smf_cell.sv
// smf_cell: one history position of the median filter row
// holds a history sample, a ring value passed from the neighbour and a running rank
// depends on smf_pkg
module smf_cell #(
	parameter int unsigned WINDOW_MAX = 9,
	parameter int unsigned INDEX      = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  smf_pkg::smf_cell_ctrl_t           ctrl,
	input  logic [$clog2(WINDOW_MAX+1)-1:0]   win,
	input  logic [$clog2(WINDOW_MAX)-1:0]     step,
	input  logic [$clog2(WINDOW_MAX)-1:0]     med_idx,
	input  smf_pkg::sample_t                  hist_in,
	input  smf_pkg::sample_t                  ring_in,
	output smf_pkg::sample_t                  hist_d,
	output smf_pkg::sample_t                  hist,
	output smf_pkg::sample_t                  ring,
	output logic                              hit
);
	import smf_pkg::*;

	localparam int unsigned CW = $clog2(WINDOW_MAX + 1);
	localparam int unsigned IW = $clog2(WINDOW_MAX);
	localparam logic [CW-1:0] INDEX_W = CW'(INDEX);
	localparam logic [IW-1:0] INDEX_I = IW'(INDEX);

	sample_t       hist_q;
	sample_t       ring_q;
	logic [IW-1:0] rank_q;
	logic          active;
	logic          less;

	assign active = INDEX_W < win;

	// ring value came from position INDEX-step (mod window); it is newer in
	// the row exactly when step <= INDEX, which breaks ties by position
	assign less = (ring_q < hist_q) || ((ring_q == hist_q) && (step <= INDEX_I));

	always_comb begin
		hist_d = hist_q;
		if (ctrl.load && active) begin
			hist_d = hist_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else begin
			hist_q <= hist_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load || ctrl.rotate) begin
			ring_q <= ring_in;
		end
		if (ctrl.load) begin
			rank_q <= '0;
		end else if (ctrl.rotate && active && less) begin
			rank_q <= rank_q + IW'(1);
		end
	end

	assign hist = hist_q;
	assign ring = ring_q;
	assign hit  = active && (rank_q == med_idx);

endmodule

FILE: design/sliding_median_filter_unit.sv
// sliding_median_filter_unit: running median filter, top level
// a row of smf_cell positions ranked by a rotating ring, sequencer and output register
// depends on smf_pkg and smf_cell
//
// Usage. Samples enter on the input channel (in_valid/in_ready, sample_in and
// block_end_in); one result beat per sample leaves on the output channel
// (out_valid/out_ready, median_out and block_end_out). With the filter on, the
// sample is shifted into the first w history positions and the result is the
// element of rank w/2 of those w values (upper middle for an even w). With the
// filter off the sample is returned as it is and the history is left alone.
// With the filter on, a sample passes a load, w-1 ranking steps of the ring that
// passes values from cell to cell and a load into the output register; with the
// filter off only the load into the output register. A new sample is taken only
// while the sequencer is idle. The output register lets the next sample in while
// a result waits; a stalled receiver holds the sequencer only once the following
// result is ready. Reset clears the history to zero, the filter to on and the
// window size to 5. Configuration writes are taken at once and must only come
// while no sample is in flight.
module sliding_median_filter_unit #(
	parameter int unsigned WINDOW_MAX = 9
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [smf_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [smf_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [smf_pkg::SAMPLE_W-1:0]   sample_in,
	input  logic                                  block_end_in,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [smf_pkg::SAMPLE_W-1:0]   median_out,
	output logic                                  block_end_out
);
	import smf_pkg::*;

	localparam int unsigned CW = $clog2(WINDOW_MAX + 1);
	localparam int unsigned IW = $clog2(WINDOW_MAX);
	localparam int unsigned EW = (CW > WSIZE_W) ? CW : WSIZE_W;

	// configuration
	logic               enable_q;
	logic [WSIZE_W-1:0] wsize_q;
	logic [EW-1:0]      wsize_ext;
	logic [CW-1:0]      win;
	logic [IW-1:0]      last_idx;
	logic [IW-1:0]      med_idx;

	// sequencer
	smf_state_t     state_q, state_d;
	logic [IW-1:0]  step_q, step_d;
	smf_cell_ctrl_t cell_ctrl;
	logic           accept;
	logic           out_load;
	logic           bypass_q;
	sample_t        pass_q;
	logic           end_q;

	// cell row
	sample_t                hist_in  [WINDOW_MAX];
	sample_t                ring_in  [WINDOW_MAX];
	sample_t                hist_d   [WINDOW_MAX];
	sample_t                hist     [WINDOW_MAX];
	sample_t                ring     [WINDOW_MAX];
	logic [WINDOW_MAX-1:0]  hit;
	sample_t                median;

	// output register
	logic    out_valid_q;
	sample_t median_q;
	logic    block_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			wsize_q  <= WSIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FILTER_ENABLE: enable_q <= cfg_data[0];
				REG_WINDOW_SIZE:   wsize_q  <= cfg_data[WSIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// effective window: zero acts as one, large values saturate
	assign wsize_ext = EW'(wsize_q);
	always_comb begin
		if (wsize_ext == '0) begin
			win = CW'(1);
		end else if (wsize_ext > EW'(WINDOW_MAX)) begin
			win = CW'(WINDOW_MAX);
		end else begin
			win = CW'(wsize_ext);
		end
	end
	assign last_idx = IW'(win - CW'(1));
	assign med_idx  = IW'(win >> 1);

	assign accept = in_valid && in_ready;

	always_comb begin
		state_d          = state_q;
		step_d           = step_q;
		in_ready         = 1'b0;
		out_load         = 1'b0;
		cell_ctrl.load   = 1'b0;
		cell_ctrl.rotate = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					step_d = IW'(1);
					if (enable_q) begin
						cell_ctrl.load = 1'b1;
						state_d = (win == CW'(1)) ? ST_OUT : ST_RANK;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_RANK: begin
				cell_ctrl.rotate = 1'b1;
				if (step_q == last_idx) begin
					state_d = ST_OUT;
				end else begin
					step_d = step_q + IW'(1);
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bypass_q <= !enable_q;
			pass_q   <= sample_in;
			end_q    <= block_end_in;
		end
	end

	// row wiring: history moves one place down, the ring closes at the window end
	genvar gi;
	generate
		for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				assign hist_in[gi] = sample_in;
				assign ring_in[gi] = cell_ctrl.load ? hist_d[last_idx] : ring[last_idx];
			end else begin : g_body
				assign hist_in[gi] = hist[gi-1];
				assign ring_in[gi] = cell_ctrl.load ? hist_d[gi-1] : ring[gi-1];
			end

			smf_cell #(
				.WINDOW_MAX (WINDOW_MAX),
				.INDEX      (gi)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (cell_ctrl),
				.win     (win),
				.step    (step_q),
				.med_idx (med_idx),
				.hist_in (hist_in[gi]),
				.ring_in (ring_in[gi]),
				.hist_d  (hist_d[gi]),
				.hist    (hist[gi]),
				.ring    (ring[gi]),
				.hit     (hit[gi])
			);
		end
	endgenerate

	// exactly one active cell holds the wanted rank
	always_comb begin
		median = '0;
		for (int i = 0; i < WINDOW_MAX; i++) begin
			if (hit[i]) begin
				median = median | hist[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			median_q    <= bypass_q ? pass_q : median;
			block_end_q <= end_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign median_out    = median_q;
	assign block_end_out = block_end_q;

	a_one_median: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) && !bypass_q |-> $onehot(hit))
		else $error("median rank not held by exactly one cell");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RANK) |-> (CW'(step_q) < win) && (step_q != '0))
		else $error("ranking step outside the window");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q)
		else $error("result beat lost at the output register");

	a_bypass_keeps_history: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !enable_q |=> hist[0] == $past(hist[0]))
		else $error("history moved while the filter is off");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cell_ctrl.load |-> (state_q == ST_IDLE) && !cell_ctrl.rotate)
		else $error("history load outside an input beat");

endmodule
